/* rtl/core/css_pkg.sv */
// css_pkg: payload types, calendar constants and month-length lookup for the
// calendar stamp successor. No dependencies; imported by every file in rtl/core.

package css_pkg;

    typedef struct packed {
        logic [63:0] candidate_stamp;
        logic [63:0] previous_stamp;
    } stamp_pair_t;

    typedef struct packed {
        logic [63:0] next_stamp;
        logic        took_candidate;
        logic [1:0]  status;
    } stamp_result_t;

    // Minute word taken apart into calendar fields, plus the remainders used
    // to rebuild the word after a month or year carry.
    typedef struct packed {
        logic [31:0] w;
        logic [19:0] ry;     // minutes into the year
        logic [15:0] rm;     // minutes into the month
        logic [3:0]  mo;     // month, 0 = January
        logic [4:0]  dq;     // day, 0 = first day
        logic [10:0] mi;     // minute of day
        logic        leap;
    } cal_fields_t;

    // register stages inside css_divide
    localparam int DIV_LAT = 6;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_DAY  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [19:0] MIN_PER_YEAR  = 20'd535680;
    localparam logic [15:0] MIN_PER_MONTH = 16'd44640;
    localparam logic [10:0] MIN_PER_DAY   = 11'd1440;
    localparam logic [10:0] LAST_MINUTE   = 11'd1439;
    localparam logic [13:0] BASE_YEAR     = 14'd1900;
    localparam logic [3:0]  MONTH_DEC     = 4'd11;
    localparam logic [4:0]  LEAP_DIVISOR  = 5'd25;

    // Exact reciprocals: divisor = 2^s * odd, quotient = ((n >> s) * R) >> k.
    localparam logic [25:0] RECIP_YEAR  = 26'(((64'd1 << 38) + 64'd4184) / 64'd4185);
    localparam logic [15:0] RECIP_MONTH = 16'(((64'd1 << 26) + 64'd1394) / 64'd1395);
    localparam logic [11:0] RECIP_DAY   = 12'(((64'd1 << 17) + 64'd44) / 64'd45);
    localparam logic [14:0] RECIP_25    = 15'(((64'd1 << 19) + 64'd24) / 64'd25);

    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mo);
        logic [4:0] len;
        case (mo)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/core/css_divide.sv */
// css_divide: six-stage pipeline that splits a minute word into year, month,
// day and minute by constant reciprocals. Depends on css_pkg.

module css_divide (
    input  logic                 clk,
    input  logic                 en,
    input  logic [31:0]          w,
    output css_pkg::cal_fields_t fields
);
    import css_pkg::*;

    // stage 1: year quotient
    logic [31:0] w1_reg;
    logic [12:0] yo1_reg, yo1_next;
    logic [50:0] prod_y;

    // stage 2: year remainder, leap divisor quotient
    logic [31:0] w2_reg;
    logic [19:0] ry2_reg, ry2_next;
    logic [13:0] y2_reg, y2_next;
    logic [9:0]  q25_reg, q25_next;
    logic [32:0] yo_scaled;
    logic [28:0] prod_25;

    // stage 3: month quotient, leap flag
    logic [31:0] w3_reg;
    logic [19:0] ry3_reg;
    logic [3:0]  mo3_reg, mo3_next;
    logic        leap3_reg, leap3_next;
    logic [30:0] prod_m;
    logic [14:0] back_25;

    // stage 4: month remainder
    logic [31:0] w4_reg;
    logic [19:0] ry4_reg;
    logic [3:0]  mo4_reg;
    logic        leap4_reg;
    logic [15:0] rm4_reg, rm4_next;
    logic [19:0] mo_scaled;

    // stage 5: day quotient
    logic [31:0] w5_reg;
    logic [19:0] ry5_reg;
    logic [3:0]  mo5_reg;
    logic        leap5_reg;
    logic [15:0] rm5_reg;
    logic [4:0]  dq5_reg, dq5_next;
    logic [22:0] prod_d;

    // stage 6: minute of day
    cal_fields_t fields_reg, fields_next;
    logic [15:0] dq_scaled;

    always_comb
    begin
        prod_y   = w[31:7] * RECIP_YEAR;
        yo1_next = prod_y[50:38];

        yo_scaled = yo1_reg * MIN_PER_YEAR;
        ry2_next  = 20'(w1_reg - yo_scaled[31:0]);
        y2_next   = 14'(yo1_reg) + BASE_YEAR;
        prod_25   = y2_next * RECIP_25;
        q25_next  = prod_25[28:19];

        prod_m   = ry2_reg[19:5] * RECIP_MONTH;
        mo3_next = prod_m[29:26];
        back_25  = q25_reg * LEAP_DIVISOR;
        // leap: divisible by 4, and not by 100 unless also by 400
        leap3_next = (y2_reg[1:0] == 2'd0)
                     && ((back_25 != 15'(y2_reg)) || (y2_reg[3:0] == 4'd0));

        mo_scaled = mo3_reg * MIN_PER_MONTH;
        rm4_next  = 16'(ry3_reg - mo_scaled);

        prod_d   = rm4_reg[15:5] * RECIP_DAY;
        dq5_next = prod_d[21:17];

        dq_scaled        = dq5_reg * MIN_PER_DAY;
        fields_next.w    = w5_reg;
        fields_next.ry   = ry5_reg;
        fields_next.rm   = rm5_reg;
        fields_next.mo   = mo5_reg;
        fields_next.dq   = dq5_reg;
        fields_next.mi   = 11'(rm5_reg - dq_scaled);
        fields_next.leap = leap5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg     <= w;
            yo1_reg    <= yo1_next;

            w2_reg     <= w1_reg;
            ry2_reg    <= ry2_next;
            y2_reg     <= y2_next;
            q25_reg    <= q25_next;

            w3_reg     <= w2_reg;
            ry3_reg    <= ry2_reg;
            mo3_reg    <= mo3_next;
            leap3_reg  <= leap3_next;

            w4_reg     <= w3_reg;
            ry4_reg    <= ry3_reg;
            mo4_reg    <= mo3_reg;
            leap4_reg  <= leap3_reg;
            rm4_reg    <= rm4_next;

            w5_reg     <= w4_reg;
            ry5_reg    <= ry4_reg;
            mo5_reg    <= mo4_reg;
            leap5_reg  <= leap4_reg;
            rm5_reg    <= rm4_reg;
            dq5_reg    <= dq5_next;

            fields_reg <= fields_next;
        end
    end

    assign fields = fields_reg;

endmodule

/* rtl/core/calendar_stamp_successor.sv */
// calendar_stamp_successor: an accepted pair beat passes the fully pipelined
// css_divide unpack (6 stages) and the repack/output register to its result
// beat; throughput one beat per cycle while the output is not stalled.
// The whole pipe advances together: it holds while the output register is full
// and result_ready is low. rst_n (async, active low) clears all valid bits;
// payload registers are not reset. Depends on css_pkg and css_divide.

module calendar_stamp_successor (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pair_valid,
    output logic                   pair_ready,
    input  css_pkg::stamp_pair_t   pair,
    output logic                   result_valid,
    input  logic                   result_ready,
    output css_pkg::stamp_result_t result
);
    import css_pkg::*;

    // Fast-path outcome that rides alongside the calendar unpack.
    typedef struct packed {
        logic        need_cal;
        logic        took;
        logic [63:0] simple;
    } side_t;

    logic                 en;
    side_t                side_next;
    side_t                side_reg [DIV_LAT];
    logic [DIV_LAT-1:0]   valid_reg;
    logic                 result_valid_reg;
    stamp_result_t        result_reg, result_next;
    cal_fields_t          fields;

    logic [4:0]  mlen;
    logic        last_min;
    logic        month_end;
    logic        bad_day;
    logic [32:0] repack;
    side_t       side_tail;

    // Advance every stage together; a full output register that is not taken
    // freezes the pipe, so nothing is dropped or repeated.
    assign en         = !result_valid_reg || result_ready;
    assign pair_ready = en;

    // Input stage: decide the cheap cases right away.
    always_comb
    begin
        side_next.took     = pair.candidate_stamp > pair.previous_stamp;
        side_next.need_cal = !side_next.took && (&pair.previous_stamp[31:0]);
        if (side_next.took)
        begin
            side_next.simple = pair.candidate_stamp;
        end
        else
        begin
            // bump the fraction without touching minutes; unused when need_cal is set
            side_next.simple = {pair.previous_stamp[63:32], pair.previous_stamp[31:0] + 32'd1};
        end
    end

    css_divide u_divide (
        .clk    (clk),
        .en     (en),
        .w      (pair.previous_stamp[63:32]),
        .fields (fields)
    );

    // Repack stage. A minute, day, month or year carry each amount to a fixed offset on
    // the word: next minute or next day is w + 1, next month is the month base
    // plus one month, next year is the year base plus one year.
    always_comb
    begin
        side_tail = side_reg[DIV_LAT-1];
        mlen      = month_days(fields.leap, fields.mo);
        last_min  = fields.mi == LAST_MINUTE;
        month_end = (fields.dq + 5'd1) == mlen;
        bad_day   = fields.dq >= mlen;

        if (!last_min || !month_end)
        begin
            repack = {1'b0, fields.w} + 33'd1;
        end
        else if (fields.mo != MONTH_DEC)
        begin
            repack = {1'b0, fields.w} - 33'(fields.rm) + 33'(MIN_PER_MONTH);
        end
        else
        begin
            repack = {1'b0, fields.w} - 33'(fields.ry) + 33'(MIN_PER_YEAR);
        end

        result_next.took_candidate = side_tail.took;
        result_next.next_stamp     = side_tail.simple;
        result_next.status         = STATUS_OK;
        if (side_tail.need_cal)
        begin
            if (bad_day)
            begin
                result_next.status     = STATUS_BAD_DAY;
                result_next.next_stamp = 64'd0;
            end
            else if (repack[32])
            begin
                result_next.status     = STATUS_OVERFLOW;
                result_next.next_stamp = 64'd0;
            end
            else
            begin
                result_next.next_stamp = {repack[31:0], 32'd0};
            end
        end
    end

    // Valid bits: cleared by reset, shifted with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg        <= {valid_reg[DIV_LAT-2:0], pair_valid};
            result_valid_reg <= valid_reg[DIV_LAT-1];
        end
    end

    // Payload: hold on stall, no reset.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/core/css_check.sv */
// css_check: port-level assertions for calendar_stamp_successor, attached by
// the bind below. Depends on css_pkg.

module css_check (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   pair_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input css_pkg::stamp_result_t result
);
    import css_pkg::*;

    // a passed-through candidate never carries an error
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.took_candidate |-> result.status == STATUS_OK)
        else $error("took_candidate with error status");

    // an error beat carries a zero stamp
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != STATUS_OK) |-> result.next_stamp == 64'd0)
        else $error("error beat with nonzero stamp");

    // a built successor is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.took_candidate && (result.status == STATUS_OK)
        |-> result.next_stamp != 64'd0)
        else $error("zero successor stamp");

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat dropped or changed under stall");

    // the input stays open while no result beat is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> pair_ready)
        else $error("input blocked with empty output");

endmodule

bind calendar_stamp_successor css_check u_css_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_ready   (pair_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

/* tb/calendar_stamp_successor_tb.sv */
// calendar_stamp_successor_tb: self-checking testbench for calendar_stamp_successor.
// Drives stamp pairs over valid/ready, predicts each successor in-line and checks
// every result beat. Depends on css_pkg and the calendar_stamp_successor RTL.

module calendar_stamp_successor_tb;

    import css_pkg::*;

    // Calendar encoding of the high word: 31 day slots per month, 12 months
    // per year, 1440 minutes per day, counted from 1900.
    localparam int unsigned YEAR_MINUTES  = 535680;
    localparam int unsigned MONTH_MINUTES = 44640;
    localparam int unsigned DAY_MINUTES   = 1440;
    localparam int unsigned FINAL_MINUTE  = 1439;
    localparam int unsigned EPOCH_YEAR    = 1900;
    localparam int unsigned TOP_SAFE_YEAR = 9916;   // last year that packs whole
    localparam int unsigned PIPE_LATENCY  = 7;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          pair_valid;
    logic          pair_ready;
    stamp_pair_t   pair;
    logic          result_valid;
    logic          result_ready;
    stamp_result_t result;

    // Expected successors, oldest first.
    stamp_result_t pending_successors[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned pairs_sent;
    int unsigned results_checked;
    int unsigned passthrough_seen;
    int unsigned bad_day_seen;
    int unsigned overflow_seen;
    int unsigned mismatch_count;

    calendar_stamp_successor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_ready   (pair_ready),
        .pair         (pair),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Calendar helpers
    // ------------------------------------------------------------------

    function automatic int unsigned calendar_month_days(input int unsigned yr,
                                                        input int unsigned mo);
        logic leap;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        if (mo == 2)
            return leap ? 29 : 28;
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
            return 30;
        return 31;
    endfunction

    // Pack a calendar minute into the high word (day may be any slot 1..31).
    function automatic logic [31:0] minute_word(input int unsigned yr, input int unsigned mo,
                                                input int unsigned dy, input int unsigned mi);
        logic [63:0] slots;
        slots = (64'(yr - EPOCH_YEAR) * 12 + 64'(mo - 1)) * 31 + 64'(dy - 1);
        slots = slots * DAY_MINUTES + 64'(mi);
        return slots[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Predictor: the smallest stamp strictly after the previous one, unless
    // the candidate already beats it.
    // ------------------------------------------------------------------

    function automatic stamp_result_t predict_successor(input stamp_pair_t p);
        stamp_result_t r;
        logic [31:0]   w;
        logic [63:0]   packed_minutes;
        int unsigned   yr;
        int unsigned   mo;
        int unsigned   dy;
        int unsigned   mi;
        r = '0;
        r.status = STATUS_OK;
        if (p.candidate_stamp > p.previous_stamp)
        begin
            r.next_stamp     = p.candidate_stamp;
            r.took_candidate = 1'b1;
            return r;
        end
        // Bump the fraction while it has room; no calendar check then.
        if (p.previous_stamp[31:0] != 32'hFFFF_FFFF)
        begin
            r.next_stamp = p.previous_stamp + 64'd1;
            return r;
        end
        w  = p.previous_stamp[63:32];
        yr = w / YEAR_MINUTES + EPOCH_YEAR;
        mo = (w % YEAR_MINUTES) / MONTH_MINUTES + 1;
        dy = (w % MONTH_MINUTES) / DAY_MINUTES + 1;
        mi = w % DAY_MINUTES;
        if (mi >= FINAL_MINUTE)
        begin
            mi = 0;
            if (dy == calendar_month_days(yr, mo))
            begin
                dy = 1;
                if (mo == 12)
                begin
                    mo = 1;
                    yr = yr + 1;
                end
                else
                    mo = mo + 1;
            end
            else
                dy = dy + 1;
        end
        else
            mi = mi + 1;
        // A day past its month wins over a year past the encoding.
        if (dy < 1 || dy > calendar_month_days(yr, mo))
        begin
            r.status = STATUS_BAD_DAY;
            return r;
        end
        packed_minutes = (64'(yr - EPOCH_YEAR) * 12 + 64'(mo - 1)) * 31 + 64'(dy - 1);
        packed_minutes = packed_minutes * DAY_MINUTES + 64'(mi);
        if (packed_minutes > 64'hFFFF_FFFF)
        begin
            r.status = STATUS_OVERFLOW;
            return r;
        end
        r.next_stamp = {packed_minutes[31:0], 32'h0};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin : check_result
        stamp_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_successors.size() == 0)
                report_mismatch($sformatf("result beat with nothing pending: %h", result));
            else
            begin
                want = pending_successors.pop_front();
                results_checked++;
                if (want.took_candidate) passthrough_seen++;
                if (want.status == STATUS_BAD_DAY) bad_day_seen++;
                if (want.status == STATUS_OVERFLOW) overflow_seen++;
                if (result.next_stamp !== want.next_stamp)
                    report_mismatch($sformatf("next_stamp got %h want %h",
                                              result.next_stamp, want.next_stamp));
                if (result.took_candidate !== want.took_candidate)
                    report_mismatch($sformatf("took_candidate got %b want %b",
                                              result.took_candidate, want.took_candidate));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, want.status));
            end
        end
    end

    // Stall the result channel at the current rate.
    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one pair beat and hold it until accepted; record its prediction.
    task automatic send_pair(input logic [63:0] cand, input logic [63:0] prev);
        stamp_pair_t p;
        p.candidate_stamp = cand;
        p.previous_stamp  = prev;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair       <= p;
        pair_valid <= 1'b1;
        @(posedge clk);
        while (!pair_ready)
            @(posedge clk);
        pending_successors.push_back(predict_successor(p));
        pairs_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_until_drained();
        pair_valid <= 1'b0;
        @(posedge clk);
        while (pending_successors.size() != 0)
            @(posedge clk);
    endtask

    // Calendar stamp with an exhausted fraction, so the minute must advance.
    function automatic logic [63:0] full_fraction(input int unsigned yr, input int unsigned mo,
                                                  input int unsigned dy, input int unsigned mi);
        return {minute_word(yr, mo, dy, mi), 32'hFFFF_FFFF};
    endfunction

    // A candidate at or below prev (wraps above when prev is small).
    function automatic logic [63:0] stale_candidate(input logic [63:0] prev);
        if ($urandom_range(3) == 0)
            return prev;
        return prev - ({$urandom, $urandom} >> $urandom_range(63));
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    task automatic test_passthrough();
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_pair(64'h1, 64'h0);
        send_pair(64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF);
    endtask

    task automatic test_fraction_bump();
        send_pair(64'h0, 64'h0);                                    // equal stamps
        send_pair(64'h0, 64'h1234_5678_9ABC_DEF0);
        send_pair(64'h0, 64'h8000_0000_FFFF_FFFE);                  // top bit of minute word
        send_pair(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // equal, very top
    endtask

    task automatic test_calendar_carry();
        send_pair(64'h0, 64'h0000_0000_FFFF_FFFF);                  // first minute of 1900
        send_pair(64'h0, full_fraction(2024, 6, 15, 600));          // minute step
        send_pair(64'h0, full_fraction(2024, 6, 15, FINAL_MINUTE)); // day step
        send_pair(64'h0, full_fraction(2023, 4, 30, FINAL_MINUTE)); // month end
        send_pair(64'h0, full_fraction(2023, 12, 31, FINAL_MINUTE)); // year end
        send_pair(64'h0, full_fraction(2024, 2, 28, FINAL_MINUTE)); // leap year
        send_pair(64'h0, full_fraction(2023, 2, 28, FINAL_MINUTE)); // common year
        send_pair(64'h0, full_fraction(2024, 2, 29, FINAL_MINUTE));
        send_pair(64'h0, full_fraction(1900, 2, 28, FINAL_MINUTE)); // century, not leap
        send_pair(64'h0, full_fraction(2000, 2, 28, FINAL_MINUTE)); // 400-year leap
        send_pair(64'h0, full_fraction(TOP_SAFE_YEAR, 12, 31, FINAL_MINUTE));
    endtask

    task automatic test_bad_day_and_overflow();
        send_pair(64'h0, full_fraction(2023, 2, 30, 5));            // slot past February
        send_pair(64'h0, full_fraction(2023, 4, 31, FINAL_MINUTE)); // day runs to 32
        send_pair(64'h0, full_fraction(2023, 2, 29, FINAL_MINUTE)); // Feb 29, common year
        send_pair(64'h0, 64'hFFFF_FFFF_FFFF_FFFF - 64'h1_0000_0000); // just under the top
        send_pair(64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF); // minute word overflows
    endtask

    // ------------------------------------------------------------------
    // Random test
    // ------------------------------------------------------------------

    task automatic test_random_mix(input int unsigned count, input int unsigned send_pct,
                                   input int unsigned recv_pct);
        logic [63:0] prev;
        logic [63:0] cand;
        int unsigned kind;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned mi;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            kind = $urandom_range(99);
            if (kind < 25)
            begin
                // Unconstrained: hits every bit and both orderings.
                prev = {$urandom, $urandom};
                cand = {$urandom, $urandom};
            end
            else if (kind < 40)
            begin
                // Fraction with room to grow.
                prev = {$urandom, $urandom};
                if ($urandom_range(7) == 0)
                    prev[31:0] = 32'hFFFF_FFFE;
                cand = stale_candidate(prev);
            end
            else if (kind < 85)
            begin
                // Well-formed calendar stamp, biased to day and month ends.
                if ($urandom_range(3) == 0)
                    yr = EPOCH_YEAR + 100 * $urandom_range(80);
                else
                    yr = EPOCH_YEAR + $urandom_range(TOP_SAFE_YEAR - EPOCH_YEAR);
                mo = $urandom_range(1, 12);
                case ($urandom_range(4))
                    0, 1:    dy = calendar_month_days(yr, mo);
                    2:       dy = $urandom_range(1, 31);
                    default: dy = $urandom_range(1, calendar_month_days(yr, mo));
                endcase
                case ($urandom_range(5))
                    0, 1, 2: mi = FINAL_MINUTE;
                    3:       mi = FINAL_MINUTE - 1;
                    default: mi = $urandom_range(FINAL_MINUTE);
                endcase
                prev = full_fraction(yr, mo, dy, mi);
                cand = stale_candidate(prev);
            end
            else if (kind < 95)
            begin
                // Any minute word with an exhausted fraction.
                prev = {$urandom, 32'hFFFF_FFFF};
                cand = stale_candidate(prev);
            end
            else
            begin
                // Top of the encoding.
                prev = {32'hFFFF_FFFF - 32'($urandom_range(3000)), 32'hFFFF_FFFF};
                cand = stale_candidate(prev);
            end
            send_pair(cand, prev);
        end
        wait_until_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          <= 1'b0;
        pair_valid     <= 1'b0;
        pair           <= '0;
        send_idle_pct   = 16;
        recv_idle_pct   = 46;
        pairs_sent      = 0;
        results_checked = 0;
        passthrough_seen = 0;
        bad_day_seen    = 0;
        overflow_seen   = 0;
        mismatch_count  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_fraction_bump();
        test_calendar_carry();
        test_bad_day_and_overflow();
        // Hold off until the directed beats are all back.
        wait_until_drained();

        test_random_mix(470, 16, 46);
        test_random_mix(470, 46, 16);
        test_random_mix(460, 0, 0);

        // Let any stray beat surface before judging.
        repeat (2 * PIPE_LATENCY + 2) @(posedge clk);
        if (pending_successors.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_successors.size()));

        $display("Covered %0d stamp pairs, %0d results checked: %0d passed through,",
                 pairs_sent, results_checked, passthrough_seen);
        $display("%0d invalid days and %0d encoding overflows.", bad_day_seen, overflow_seen);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* calendar_stamp_successor.f */
rtl/core/css_pkg.sv
rtl/core/css_divide.sv
rtl/core/calendar_stamp_successor.sv
rtl/core/css_check.sv
tb/calendar_stamp_successor_tb.sv
